@@ rtl/fppr_pkg.sv @@
// shared types, codes and helpers of the flash ping-pong record writer
// no dependencies

package fppr_pkg;

   localparam int HDR_BYTES   = 8;
   localparam int MAX_PAYLOAD = 4088;
   localparam int REQ_DATA_W  = 160;
   localparam int RSP_DATA_W  = 112;

   typedef enum logic [2:0] {
      CMD_MOUNT  = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_DONE   = 3'd2,
      CMD_STATUS = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_code_type;

   typedef enum logic [2:0] {
      OP_DONE   = 3'd0,
      OP_WREN   = 3'd1,
      OP_ERASE  = 3'd2,
      OP_PROG   = 3'd3,
      OP_STATUS = 3'd4,
      OP_REPORT = 3'd5,
      OP_REJECT = 3'd6
   } op_code_type;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'b00001,
      PH_ERASE_SEND = 5'b00010,
      PH_ERASE_WAIT = 5'b00100,
      PH_WRITE_SEND = 5'b01000,
      PH_WRITE_WAIT = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [23:0] address;
      logic [8:0]  count;
      logic [11:0] offset;
      logic [31:0] sequence_nr;
      logic [15:0] size;
      logic [7:0]  checksum;
      logic [5:0]  block;
      logic        busy;
      logic        last;
   } beat_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic beat_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] exec_beats;
      logic       two_beats;
   } dp_status_type;

   function automatic logic [7:0] hdr_sum(input logic [31:0] seq, input logic [15:0] size,
                                         input logic [7:0] flags);
      logic [7:0] s;
      s = seq[7:0] + seq[15:8] + seq[23:16] + seq[31:24] + size[7:0] + size[15:8] + flags;
      return s;
   endfunction

endpackage

@@ rtl/fppr_ram.sv @@
// generic single-write, single-read ram with registered read
// no dependencies

module fppr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fppr_ctrl.sv @@
// item sequencer: accept, table lookup, execute, result beats
// depends on fppr_pkg

module fppr_ctrl import fppr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          rsp_tlast,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_SEND0  = 5'b01000,
      ST_SEND1  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            dp_cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            dp_cmd.commit = 1'b1;
            state_in = (dp_status.exec_beats == 2'd0) ? ST_IDLE : ST_SEND0;
         end
         ST_SEND0: begin
            if (rsp_tready) begin
               state_in = dp_status.two_beats ? ST_SEND1 : ST_IDLE;
            end
         end
         ST_SEND1: begin
            dp_cmd.beat_sel = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND0) || (state_ff == ST_SEND1);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result beat is pending");

   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND1) |-> rsp_tlast)
      else $error("second result beat not marked last");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND0 && dp_status.two_beats) |-> !rsp_tlast)
      else $error("first of two beats marked last");

endmodule

@@ rtl/fppr_datapath.sv @@
// file table, write sequence registers, page split and result beat builder
// depends on fppr_pkg and fppr_ram

module fppr_datapath import fppr_pkg::*; #(
   parameter int FILE_ENTRIES = 32,
   parameter int BLOCK_BYTES  = 4096,
   parameter int PAGE_BYTES   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  dp_cmd_type            dp_cmd,
   output dp_status_type         dp_status,
   output beat_type              beat
);

   localparam int DEPTH = (FILE_ENTRIES < 32) ? FILE_ENTRIES : 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LIMIT = (BLOCK_BYTES - HDR_BYTES < MAX_PAYLOAD) ?
                          BLOCK_BYTES - HDR_BYTES : MAX_PAYLOAD;
   localparam logic [12:0] PAGE13    = 13'(PAGE_BYTES);
   localparam logic [12:0] PAGE_MASK = 13'(PAGE_BYTES - 1);
   localparam logic [11:0] PAGE12    = 12'(PAGE_BYTES);
   localparam logic [8:0]  PAGE_CNT  = 9'(PAGE_BYTES % 512);
   localparam int ENT_W = 49;

   // captured item
   logic [2:0]  cmd_ff;
   logic [4:0]  file_ff;
   logic [11:0] dsz_ff;
   logic [31:0] seq_a_ff, seq_b_ff;
   logic [15:0] size_a_ff, size_b_ff;
   logic [7:0]  flags_a_ff, flags_b_ff, csum_a_ff, csum_b_ff, stat_ff;
   logic [4:0]  rd_file_ff, rd_file_in;

   // write sequence state
   phase_type   phase_ff, phase_in;
   logic [4:0]  act_file_ff, act_file_in;
   logic [11:0] act_size_ff, act_size_in;
   logic [23:0] page_addr_ff, page_addr_in;
   logic [11:0] page_off_ff, page_off_in;

   logic [DEPTH-1:0] valid_ff;
   logic        ent_valid_ff;
   logic        two_ff;
   beat_type    b0_ff, b1_ff, b0, b1;
   logic [1:0]  nbeats;

   logic             wr_en;
   logic [ENT_W-1:0] wr_data, rd_data;
   logic [2:0]       in_cmd;
   logic [4:0]       in_file;

   logic        ent_sel;
   logic [15:0] ent_size;
   logic [31:0] ent_seq;
   logic [5:0]  blk_cur;
   logic        f_ok, va, vb, m_sel;
   logic [31:0] m_seq, seq_inc;
   logic [15:0] m_size;
   logic [12:0] total_v, rem_v, off_v;
   logic [11:0] step;

   assign in_cmd  = req_tuser;
   assign in_file = req_tdata[4:0];
   assign rd_file_in = (in_cmd == CMD_DONE || in_cmd == CMD_STATUS) ? act_file_ff : in_file;

   fppr_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_file_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (dp_cmd.capture),
      .rd_addr (rd_file_in[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // entries never written read as zero
   assign ent_sel  = ent_valid_ff & rd_data[0];
   assign ent_size = ent_valid_ff ? rd_data[16:1] : 16'd0;
   assign ent_seq  = ent_valid_ff ? rd_data[48:17] : 32'd0;
   assign blk_cur  = {rd_file_ff, ent_sel};
   assign f_ok     = 32'(file_ff) < FILE_ENTRIES;
   assign seq_inc  = ent_seq + 32'd1;
   assign total_v  = 13'(act_size_ff) + 13'(HDR_BYTES);

   always_comb begin
      va = (hdr_sum(seq_a_ff, size_a_ff, flags_a_ff) == csum_a_ff);
      vb = (hdr_sum(seq_b_ff, size_b_ff, flags_b_ff) == csum_b_ff);
      if (va && !(vb && seq_b_ff > seq_a_ff)) begin
         m_sel = 1'b0; m_seq = seq_a_ff; m_size = size_a_ff;
      end else if (vb) begin
         m_sel = 1'b1; m_seq = seq_b_ff; m_size = size_b_ff;
      end else begin
         m_sel = 1'b0; m_seq = 32'd1; m_size = 16'd0;
      end
      if (m_size == 16'hFFFF) m_size = 16'd0;
      if (m_seq == 32'hFFFF_FFFF) m_seq = 32'd0;
   end

   always_comb begin
      nbeats       = 2'd0;
      b0           = '0;
      b1           = '0;
      b0.last      = 1'b1;
      b1.last      = 1'b1;
      wr_en        = 1'b0;
      wr_data      = {ent_seq, ent_size, ent_sel};
      phase_in     = phase_ff;
      act_file_in  = act_file_ff;
      act_size_in  = act_size_ff;
      page_addr_in = page_addr_ff;
      page_off_in  = page_off_ff;
      // page size is a power of two, so the split is a mask
      rem_v        = total_v & PAGE_MASK;
      off_v        = total_v & ~PAGE_MASK;
      step         = (PAGE12 > page_off_ff) ? page_off_ff : PAGE12;
      b0.op        = OP_REJECT;
      case (cmd_ff) inside
         CMD_MOUNT, CMD_QUERY: begin
            nbeats = 2'd1;
            if (f_ok && !(cmd_ff == CMD_MOUNT && phase_ff != PH_IDLE)) begin
               b0.op = OP_REPORT;
               if (cmd_ff == CMD_MOUNT) begin
                  wr_en          = 1'b1;
                  wr_data        = {m_seq, m_size, m_sel};
                  b0.sequence_nr = m_seq;
                  b0.size        = m_size;
                  b0.block       = {rd_file_ff, m_sel};
               end else begin
                  b0.sequence_nr = ent_seq;
                  b0.size        = ent_size;
                  b0.block       = blk_cur;
               end
            end
         end
         CMD_WRITE: begin
            nbeats = 2'd1;
            if (phase_ff == PH_IDLE && f_ok && 32'(dsz_ff) <= LIMIT) begin
               nbeats       = 2'd2;
               act_file_in  = file_ff;
               act_size_in  = dsz_ff;
               page_addr_in = 24'(32'({rd_file_ff, ~ent_sel}) * BLOCK_BYTES);
               page_off_in  = 12'd0;
               phase_in     = PH_ERASE_SEND;
               b0.op        = OP_WREN;
               b0.block     = blk_cur;
               b0.last      = 1'b0;
               b1.op        = OP_ERASE;
               b1.address   = page_addr_in;
               b1.block     = blk_cur;
            end
         end
         CMD_DONE: begin
            if (phase_ff == PH_ERASE_SEND || phase_ff == PH_WRITE_SEND) begin
               nbeats   = 2'd1;
               phase_in = (phase_ff == PH_ERASE_SEND) ? PH_ERASE_WAIT : PH_WRITE_WAIT;
               b0.op    = OP_STATUS;
               b0.block = blk_cur;
            end
         end
         CMD_STATUS: begin
            if (phase_ff == PH_ERASE_WAIT || phase_ff == PH_WRITE_WAIT) begin
               nbeats   = 2'd1;
               b0.block = blk_cur;
               if (stat_ff[0]) begin
                  b0.op = OP_STATUS;
               end else if (phase_ff == PH_ERASE_WAIT) begin
                  // partial page goes first, a full last page when it divides evenly
                  if (rem_v == 13'd0) begin
                     rem_v = PAGE13;
                     off_v = off_v - PAGE13;
                  end
                  nbeats         = 2'd2;
                  wr_en          = 1'b1;
                  wr_data        = {seq_inc, 4'd0, act_size_ff, ent_sel};
                  page_off_in    = off_v[11:0];
                  page_addr_in   = page_addr_ff + 24'(page_off_in);
                  phase_in       = PH_WRITE_SEND;
                  b0.op          = OP_WREN;
                  b0.last        = 1'b0;
                  b1.op          = OP_PROG;
                  b1.address     = page_addr_in;
                  b1.count       = rem_v[8:0];
                  b1.offset      = page_off_in;
                  b1.sequence_nr = seq_inc;
                  b1.size        = {4'd0, act_size_ff};
                  b1.checksum    = hdr_sum(seq_inc, {4'd0, act_size_ff}, 8'd0);
                  b1.block       = blk_cur;
               end else if (page_off_ff != 12'd0) begin
                  nbeats       = 2'd2;
                  page_off_in  = page_off_ff - step;
                  page_addr_in = page_addr_ff - 24'(step);
                  phase_in     = PH_WRITE_SEND;
                  b0.op        = OP_WREN;
                  b0.last      = 1'b0;
                  b1.op        = OP_PROG;
                  b1.address   = page_addr_in;
                  b1.count     = PAGE_CNT;
                  b1.offset    = page_off_in;
                  b1.block     = blk_cur;
               end else begin
                  wr_en          = 1'b1;
                  wr_data        = {ent_seq, ent_size, ~ent_sel};
                  phase_in       = PH_IDLE;
                  b0.op          = OP_DONE;
                  b0.sequence_nr = ent_seq;
                  b0.size        = ent_size;
                  b0.block       = {rd_file_ff, ~ent_sel};
               end
            end
         end
         default: nbeats = 2'd1;
      endcase
      b0.busy = (phase_in != PH_IDLE);
      b1.busy = (phase_in != PH_IDLE);
      if (!dp_cmd.commit) begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff       <= in_cmd;
         file_ff      <= in_file;
         dsz_ff       <= req_tdata[16:5];
         seq_a_ff     <= req_tdata[48:17];
         size_a_ff    <= req_tdata[64:49];
         flags_a_ff   <= req_tdata[72:65];
         csum_a_ff    <= req_tdata[80:73];
         seq_b_ff     <= req_tdata[112:81];
         size_b_ff    <= req_tdata[128:113];
         flags_b_ff   <= req_tdata[136:129];
         csum_b_ff    <= req_tdata[144:137];
         stat_ff      <= req_tdata[152:145];
         rd_file_ff   <= rd_file_in;
         ent_valid_ff <= valid_ff[rd_file_in[IDX_W-1:0]];
      end
      if (dp_cmd.commit) begin
         b0_ff  <= b0;
         b1_ff  <= b1;
         two_ff <= (nbeats == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         act_file_ff  <= '0;
         act_size_ff  <= '0;
         page_addr_ff <= '0;
         page_off_ff  <= '0;
         valid_ff     <= '0;
      end else if (dp_cmd.commit) begin
         phase_ff     <= phase_in;
         act_file_ff  <= act_file_in;
         act_size_ff  <= act_size_in;
         page_addr_ff <= page_addr_in;
         page_off_ff  <= page_off_in;
         if (wr_en) begin
            valid_ff[rd_file_ff[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   assign dp_status.exec_beats = nbeats;
   assign dp_status.two_beats  = two_ff;
   assign beat = dp_cmd.beat_sel ? b1_ff : b0_ff;

   a_page_pow2: assert property (@(posedge clock) disable iff (reset)
      (PAGE_BYTES & (PAGE_BYTES - 1)) == 0)
      else $error("page size is not a power of two");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("write phase not one-hot");

   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      (13'(page_off_ff) & PAGE_MASK) == 13'd0)
      else $error("page offset off a page boundary");

endmodule

@@ rtl/flash_ping_pong_record_writer.sv @@
// Ping-pong record store sequencer for a serial flash: keeps a per-file table (current
// block, size, sequence), answers mount and query with an entry report and steps a write
// through enable, erase, status polls and page programs, last page first, on the other block.
// An item passes accept, lookup and execute states, then a send state per result beat held
// until taken; the page split is a combinational mask on the power-of-two page size.
// Depends on fppr_pkg, fppr_ctrl, fppr_datapath and fppr_ram.

module flash_ping_pong_record_writer import fppr_pkg::*; #(
   parameter int FILE_ENTRIES = 32,
   parameter int BLOCK_BYTES  = 4096,
   parameter int PAGE_BYTES   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // file_index, payload_bytes, seq_a, size_a, flags_a, csum_a, seq_b, size_b, flags_b,
   // csum_b, status_byte, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // flash_address, byte_count, buffer_offset, record_sequence, record_size,
   // header_checksum, current_block, busy_res, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // flash_op
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   beat_type      beat;

   fppr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   fppr_datapath #(
      .FILE_ENTRIES (FILE_ENTRIES),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .beat      (beat)
   );

   assign rsp_tdata = {4'd0, beat.busy, beat.block, beat.checksum, beat.size,
                       beat.sequence_nr, beat.offset, beat.count, beat.address};
   assign rsp_tuser = beat.op;
   assign rsp_tlast = beat.last;

endmodule
